// ===== rtl/ipg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_pkg: shared definitions for the integer partition generator
// Field widths, command and status codes, register indexes, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ipg_pkg;

	localparam int MAX_TOTAL_DEFAULT = 64;

	localparam int PART_W    = 7;
	localparam int CFG_W     = 7;
	localparam int LIMIT_W   = 31;
	localparam int ROWS_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_ADVANCE = 1'b1
	} command_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ROW      = 2'd0,
		STAT_SKIPPED  = 2'd1,
		STAT_FINISHED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_VALUE = 2'd0,
		REG_MAX_PARTS   = 2'd1,
		REG_MIN_FIRST   = 2'd2,
		REG_ROW_LIMIT   = 2'd3
	} cfg_reg_t;

	// Read port address selection of the part store.
	typedef enum logic [2:0] {
		RD_NONE,
		RD_FIRST,
		RD_TAIL,
		RD_EMIT_SAME,
		RD_EMIT_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV_HEAD,
		S_ADV_CHECK,
		S_REFILL,
		S_LOAD_ROW,
		S_STEP_ROW,
		S_EMIT,
		S_MARK
	} state_t;

	typedef struct packed {
		logic    do_load;
		logic    latch_first;
		logic    step_go;
		logic    refill_go;
		logic    count_row;
		logic    emit_init;
		logic    emit_load;
		logic    mark_load;
		status_t mark_code;
		rd_sel_t rd_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic load_open;
		logic finished;
		logic chk_fail;
		logic chk_two;
		logic refill_more;
		logic too_long;
		logic emit_last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ipg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_ctrl: sequencing controller
// Accepts input transactions, walks the datapath through the check, refill
// and row emission steps, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module ipg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             command,
	input  wire logic             load_last,
	input  wire logic             out_ready,
	input  wire ipg_pkg::dp_stat_t stat,
	output logic                  in_ready,
	output logic                  out_valid,
	output ipg_pkg::dp_cmd_t      cmd
);

	ipg_pkg::state_t  state_q, state_d;
	ipg_pkg::status_t mark_q, mark_d;
	logic             out_valid_q, out_valid_d;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipg_pkg::S_IDLE;
			mark_q      <= ipg_pkg::STAT_ROW;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mark_q      <= mark_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mark_d        = mark_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.mark_code = mark_q;
		cmd.rd_sel    = ipg_pkg::RD_NONE;
		unique case (state_q)
			ipg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (command == ipg_pkg::CMD_LOAD) begin
						cmd.do_load = 1'b1;
						if (load_last) begin
							state_d = ipg_pkg::S_LOAD_ROW;
						end
					end else if (!stat.load_open) begin
						if (stat.finished) begin
							mark_d  = ipg_pkg::STAT_FINISHED;
							state_d = ipg_pkg::S_MARK;
						end else begin
							cmd.rd_sel = ipg_pkg::RD_FIRST;
							state_d    = ipg_pkg::S_ADV_HEAD;
						end
					end
				end
			end
			ipg_pkg::S_ADV_HEAD: begin
				cmd.latch_first = 1'b1;
				cmd.rd_sel      = ipg_pkg::RD_TAIL;
				state_d         = ipg_pkg::S_ADV_CHECK;
			end
			ipg_pkg::S_ADV_CHECK: begin
				cmd.step_go = 1'b1;
				if (stat.chk_fail) begin
					mark_d  = ipg_pkg::STAT_FINISHED;
					state_d = ipg_pkg::S_MARK;
				end else if (stat.chk_two) begin
					state_d = ipg_pkg::S_STEP_ROW;
				end else begin
					state_d = ipg_pkg::S_REFILL;
				end
			end
			ipg_pkg::S_REFILL: begin
				cmd.refill_go = 1'b1;
				if (!stat.refill_more) begin
					state_d = ipg_pkg::S_STEP_ROW;
				end
			end
			ipg_pkg::S_LOAD_ROW, ipg_pkg::S_STEP_ROW: begin
				if (stat.too_long) begin
					mark_d  = ipg_pkg::STAT_SKIPPED;
					state_d = ipg_pkg::S_MARK;
				end else begin
					cmd.count_row = (state_q == ipg_pkg::S_STEP_ROW);
					cmd.emit_init = 1'b1;
					cmd.rd_sel    = ipg_pkg::RD_FIRST;
					state_d       = ipg_pkg::S_EMIT;
				end
			end
			ipg_pkg::S_EMIT: begin
				if (out_free) begin
					cmd.emit_load = 1'b1;
					cmd.rd_sel    = ipg_pkg::RD_EMIT_NEXT;
					if (stat.emit_last) begin
						state_d = ipg_pkg::S_IDLE;
					end
				end else begin
					cmd.rd_sel = ipg_pkg::RD_EMIT_SAME;
				end
			end
			ipg_pkg::S_MARK: begin
				if (out_free) begin
					cmd.mark_load = 1'b1;
					state_d       = ipg_pkg::S_IDLE;
				end
			end
		endcase

		if (cmd.emit_load || cmd.mark_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ipg_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_datapath: part store, configuration and successor arithmetic
// Holds the partition in a single-port-read memory, performs one refill
// write per cycle and drives the output payload register.
// ----------------------------------------------------------------------------
module ipg_datapath #(
	parameter int MAX_TOTAL = ipg_pkg::MAX_TOTAL_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ipg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ipg_pkg::LIMIT_W-1:0]     cfg_data,
	input  wire logic [ipg_pkg::PART_W-1:0]      part_value,
	input  wire logic                            load_last,
	input  wire ipg_pkg::dp_cmd_t                cmd,
	output ipg_pkg::dp_stat_t                    stat,
	output logic [ipg_pkg::PART_W-1:0]           part,
	output logic                                 row_end,
	output logic [ipg_pkg::STATUS_W-1:0]         status
);

	localparam int IW = $clog2(MAX_TOTAL + 1);
	localparam int TW = ipg_pkg::PART_W + 1;
	localparam logic [IW-1:0] MAX_IDX = IW'(MAX_TOTAL);
	localparam logic [ipg_pkg::CFG_W-1:0] MAX_CFG = ipg_pkg::CFG_W'(MAX_TOTAL);

	// Configuration registers.
	logic [ipg_pkg::CFG_W-1:0]   total_q, maxp_q, minf_q;
	logic [ipg_pkg::LIMIT_W-1:0] limit_q;

	// Partition state. Entries above top_q read as one.
	logic [ipg_pkg::PART_W-1:0] store_mem [0:MAX_TOTAL];
	logic [IW-1:0]              top_q, tail_q, count_q;
	logic [ipg_pkg::ROWS_W-1:0] rows_q;
	logic                       fin_q, open_q;

	// Working registers.
	logic [ipg_pkg::PART_W-1:0] rd_q, p1_q, r_q;
	logic                       ones_q;
	logic [TW-1:0]              t_q;
	logic [IW-1:0]              emit_i_q;
	logic [ipg_pkg::PART_W-1:0] part_q;
	logic                       row_end_q;
	ipg_pkg::status_t           status_q;

	logic [IW-1:0]              k_len, cap_len;
	logic [IW-1:0]              base_count, base_tail, new_count, h_inc;
	logic                       store_ok, h_bad, h_lt;
	logic [ipg_pkg::PART_W-1:0] rd_val, r_new;
	logic [TW-1:0]              m_plus1, h_ext, t_new;
	logic [ipg_pkg::ROWS_W-1:0] rows_inc;
	logic [IW:0]                emit_plus2;

	logic                       we, rd_en;
	logic [IW-1:0]              waddr, raddr;
	logic [ipg_pkg::PART_W-1:0] wdata;

	// Clamped row length and load capacity.
	always_comb begin
		if (maxp_q == '0) begin
			k_len = IW'(1);
		end else if (maxp_q > MAX_CFG) begin
			k_len = MAX_IDX;
		end else begin
			k_len = maxp_q[IW-1:0];
		end
		if (total_q == '0) begin
			cap_len = IW'(1);
		end else if (total_q > MAX_CFG) begin
			cap_len = MAX_IDX;
		end else begin
			cap_len = total_q[IW-1:0];
		end
	end

	assign rd_val     = ones_q ? ipg_pkg::PART_W'(1) : rd_q;
	assign base_count = open_q ? count_q : '0;
	assign base_tail  = open_q ? tail_q : IW'(1);
	assign store_ok   = ipg_pkg::CFG_W'(base_count) < ipg_pkg::CFG_W'(cap_len);
	assign new_count  = base_count + IW'(1);

	assign h_bad   = (tail_q == '0) || (tail_q > MAX_IDX);
	assign h_lt    = tail_q < MAX_IDX;
	assign h_inc   = tail_q + IW'(1);
	assign r_new   = rd_val - ipg_pkg::PART_W'(1);
	assign m_plus1 = TW'(count_q) + TW'(1);
	assign h_ext   = TW'(tail_q);
	assign t_new   = (m_plus1 >= h_ext) ? (m_plus1 - h_ext) : '0;

	assign rows_inc   = rows_q + ipg_pkg::ROWS_W'(1);
	assign emit_plus2 = (IW + 1)'(emit_i_q) + (IW + 1)'(2);

	assign stat.load_open   = open_q;
	assign stat.finished    = fin_q;
	assign stat.chk_fail    = (p1_q < minf_q) || (p1_q <= ipg_pkg::PART_W'(1)) || h_bad
		|| (rd_val < ipg_pkg::PART_W'(2));
	assign stat.chk_two     = rd_val == ipg_pkg::PART_W'(2);
	assign stat.refill_more = (t_q >= TW'(r_q)) && h_lt;
	assign stat.too_long    = count_q > k_len;
	assign stat.emit_last   = emit_i_q == (k_len - IW'(1));

	// Single write port.
	always_comb begin
		we    = 1'b0;
		waddr = tail_q;
		wdata = r_q;
		if (cmd.do_load && store_ok) begin
			we    = 1'b1;
			waddr = new_count;
			wdata = part_value;
		end else if (cmd.step_go && !stat.chk_fail) begin
			we    = 1'b1;
			waddr = tail_q;
			wdata = stat.chk_two ? ipg_pkg::PART_W'(1) : r_new;
		end else if (cmd.refill_go) begin
			if (stat.refill_more) begin
				we    = 1'b1;
				waddr = h_inc;
				wdata = r_q;
			end else if ((t_q > TW'(1)) && h_lt) begin
				we    = 1'b1;
				waddr = h_inc;
				wdata = t_q[ipg_pkg::PART_W-1:0];
			end
		end
	end

	// Single read port.
	always_comb begin
		rd_en = 1'b1;
		raddr = '0;
		unique case (cmd.rd_sel)
			ipg_pkg::RD_NONE:      rd_en = 1'b0;
			ipg_pkg::RD_FIRST:     raddr = IW'(1);
			ipg_pkg::RD_TAIL:      raddr = h_bad ? '0 : tail_q;
			ipg_pkg::RD_EMIT_SAME: raddr = emit_i_q + IW'(1);
			ipg_pkg::RD_EMIT_NEXT: begin
				raddr = (emit_plus2 > (IW + 1)'(MAX_TOTAL)) ? '0 : emit_plus2[IW-1:0];
			end
			default:               rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q   <= store_mem[raddr];
			ones_q <= raddr > top_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= ipg_pkg::CFG_W'(1);
			maxp_q  <= ipg_pkg::CFG_W'(1);
			minf_q  <= ipg_pkg::CFG_W'(1);
			limit_q <= '0;
			top_q   <= '0;
			tail_q  <= IW'(1);
			count_q <= '0;
			rows_q  <= ipg_pkg::ROWS_W'(1);
			fin_q   <= 1'b0;
			open_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (ipg_pkg::cfg_reg_t'(cfg_index))
					ipg_pkg::REG_TOTAL_VALUE: total_q <= cfg_data[ipg_pkg::CFG_W-1:0];
					ipg_pkg::REG_MAX_PARTS:   maxp_q  <= cfg_data[ipg_pkg::CFG_W-1:0];
					ipg_pkg::REG_MIN_FIRST:   minf_q  <= cfg_data[ipg_pkg::CFG_W-1:0];
					ipg_pkg::REG_ROW_LIMIT:   limit_q <= cfg_data;
				endcase
			end

			// A stored load part sets the top of the written range; refill
			// writes only ever extend it.
			if (cmd.do_load && store_ok) begin
				top_q <= new_count;
			end else if (we && (waddr > top_q)) begin
				top_q <= waddr;
			end

			if (cmd.do_load) begin
				if (!open_q) begin
					rows_q <= ipg_pkg::ROWS_W'(1);
					fin_q  <= 1'b0;
				end
				open_q <= !load_last;
				if (store_ok) begin
					count_q <= new_count;
					tail_q  <= (part_value > ipg_pkg::PART_W'(1)) ? new_count : base_tail;
				end else begin
					count_q <= base_count;
					tail_q  <= base_tail;
				end
			end

			if (cmd.step_go) begin
				if (stat.chk_fail) begin
					fin_q <= 1'b1;
				end else if (stat.chk_two) begin
					count_q <= (count_q < MAX_IDX) ? count_q + IW'(1) : count_q;
					tail_q  <= tail_q - IW'(1);
				end
			end

			if (cmd.refill_go) begin
				if (stat.refill_more) begin
					tail_q <= h_inc;
				end else begin
					if (t_q == '0) begin
						count_q <= tail_q;
					end else begin
						count_q <= h_lt ? h_inc : MAX_IDX;
					end
					if ((t_q > TW'(1)) && h_lt) begin
						tail_q <= h_inc;
					end
				end
			end

			if (cmd.count_row) begin
				rows_q <= rows_inc;
				if (rows_inc == ipg_pkg::ROWS_W'(limit_q)) begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_first) begin
			p1_q <= rd_val;
		end
		if (cmd.step_go && !stat.chk_fail && !stat.chk_two) begin
			r_q <= r_new;
			t_q <= t_new;
		end else if (cmd.refill_go && stat.refill_more) begin
			t_q <= t_q - TW'(r_q);
		end
		if (cmd.emit_init) begin
			emit_i_q <= '0;
		end else if (cmd.emit_load) begin
			emit_i_q <= emit_i_q + IW'(1);
		end
		if (cmd.emit_load) begin
			part_q    <= (emit_i_q < count_q) ? rd_val : '0;
			row_end_q <= stat.emit_last;
			status_q  <= ipg_pkg::STAT_ROW;
		end else if (cmd.mark_load) begin
			part_q    <= '0;
			row_end_q <= 1'b1;
			status_q  <= cmd.mark_code;
		end
	end

	assign part    = part_q;
	assign row_end = row_end_q;
	assign status  = status_q;

endmodule
`default_nettype wire

// ===== rtl/integer_partition_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_partition_generator: ZS1 integer partition generator
// Loads a start partition part by part, then steps through the partitions
// of total_value in reverse lexicographic order, one per advance, emitting
// each as a zero-padded row of max_parts parts.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake          Payload                      Direction
//  -------  -----------------  ---------------------------  ---------
//  input    in_valid/in_ready  command, part_value,         in
//                              load_last
//  output   out_valid/out_ready part, row_end, status       out
//  config   cfg_we             cfg_index, cfg_data          in
//
// The part store has one write and one read port, so the refill writes
// one part per cycle and the row streams out one part per cycle through
// the registered read port while the output is not stalled.
// Markers (skipped or finished) pass through the marker state into the
// output register.
// Reset clears the controller, counters and configuration to their
// defaults; the part store itself is not cleared.
// A stalled output holds the row in place; the next input transaction is
// taken as soon as the last result of the previous one is in the output
// register, even if that result has not yet been taken.
// ----------------------------------------------------------------------------
module integer_partition_generator #(
	parameter int MAX_TOTAL = ipg_pkg::MAX_TOTAL_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	input  wire logic [ipg_pkg::PART_W-1:0]    part_value,
	input  wire logic                          load_last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ipg_pkg::PART_W-1:0]         part,
	output logic                               row_end,
	output logic [ipg_pkg::STATUS_W-1:0]       status,
	input  wire logic                          cfg_we,
	input  wire logic [ipg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ipg_pkg::LIMIT_W-1:0]   cfg_data
);

	// Command and status bundles between the sequencer and the datapath.
	ipg_pkg::dp_cmd_t  dp_cmd;
	ipg_pkg::dp_stat_t dp_stat;

	// The controller decides the order of work: check the head and tail
	// parts, refill the tail one part per cycle, then stream the row or
	// raise a marker.
	ipg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (command),
		.load_last (load_last),
		.out_ready (out_ready),
		.stat      (dp_stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (dp_cmd)
	);

	// The datapath owns the part store, the configuration registers and the
	// output payload register.
	ipg_datapath #(
		.MAX_TOTAL (MAX_TOTAL)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.part_value (part_value),
		.load_last  (load_last),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.part       (part),
		.row_end    (row_end),
		.status     (status)
	);

endmodule
`default_nettype wire

// ===== rtl/ipg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_checker: port-level checks for the partition generator
// Watches the top-level ports and flags broken output transactions.
// ----------------------------------------------------------------------------
module ipg_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [ipg_pkg::PART_W-1:0]    part,
	input wire logic                          row_end,
	input wire logic [ipg_pkg::STATUS_W-1:0]  status
);

	logic row_part;

	assign row_part = out_valid && (status == ipg_pkg::STAT_ROW);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(part) && $stable(row_end)
			&& $stable(status))
		else $error("output payload changed while stalled");

	// Markers are a single zero transaction that closes its input.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ipg_pkg::STAT_ROW) |-> (part == '0) && row_end)
		else $error("marker with nonzero part or open row");

	// No new input is taken while a row is still being streamed.
	assert property (@(posedge clk) disable iff (!arst_n)
		row_part && !row_end |-> !in_ready)
		else $error("input accepted in the middle of a row");

	// Once a row part that is not the last is taken, the next part follows at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		row_part && !row_end && out_ready |=> out_valid && (status == ipg_pkg::STAT_ROW))
		else $error("row stream broken");

endmodule

bind integer_partition_generator ipg_checker u_ipg_checker (.*);
`default_nettype wire

// ===== tb/ipg_row_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipg_row_checker: row predictor and comparator for the partition generator
// Follows the input, output and register write ports, steps its own copy of
// the ZS1 generator for every accepted input transaction and compares each
// output transaction, field by field, with the oldest part still due.
// ----------------------------------------------------------------------------
module ipg_row_checker
	import ipg_pkg::*;
#(
	parameter int MAX_TOTAL = MAX_TOTAL_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 command,
	input  logic [PART_W-1:0]    part_value,
	input  logic                 load_last,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [PART_W-1:0]    part,
	input  logic                 row_end,
	input  logic [STATUS_W-1:0]  status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   rows_seen,
	output int                   skips_seen,
	output int                   finishes_seen
);

	typedef struct packed {
		logic [PART_W-1:0] part;
		logic              row_end;
		status_t           status;
	} row_item_t;

	// Register copies.
	logic [CFG_W-1:0]   n_total;
	logic [CFG_W-1:0]   k_row;
	logic [CFG_W-1:0]   first_floor;
	logic [LIMIT_W-1:0] row_cap;

	// Generator state.
	logic [PART_W-1:0] gen_parts [0:MAX_TOTAL];
	int unsigned       gen_tail;
	int unsigned       gen_count;
	logic [ROWS_W-1:0] gen_rows;
	logic              gen_done;
	logic              gen_loading;

	row_item_t due_parts [$];
	int        mismatches;
	int        result_no;
	int        n_rows, n_skips, n_finishes;

	function automatic int unsigned fit_range(logic [CFG_W-1:0] v);
		if (v < 1) return 1;
		if (v > MAX_TOTAL) return MAX_TOTAL;
		return v;
	endfunction

	function automatic void push_marker(status_t code);
		row_item_t item;
		item.part    = '0;
		item.row_end = 1'b1;
		item.status  = code;
		due_parts.push_back(item);
	endfunction

	// The current partition as a zero-padded row, or a skipped marker when it
	// does not fit in the row.
	function automatic void push_row();
		int unsigned k;
		row_item_t   item;
		k = fit_range(k_row);
		if (gen_count > k) begin
			push_marker(STAT_SKIPPED);
		end else begin
			for (int unsigned i = 0; i < k; i++) begin
				item.part    = (i < gen_count) ? gen_parts[i + 1] : '0;
				item.row_end = (i + 1 == k);
				item.status  = STAT_ROW;
				due_parts.push_back(item);
			end
		end
	endfunction

	task automatic report_mismatch(string what, int got_v, int want_v);
		mismatches++;
		// Keep the log readable when something goes badly wrong.
		if (mismatches <= 60)
			$display("[%0t] ERROR result %0d: %s is %0d, expected %0d",
				$time, result_no, what, got_v, want_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned h, m, r, t;
		row_item_t   want;
		if (!arst_n) begin
			n_total     = 7'd1;
			k_row       = 7'd1;
			first_floor = 7'd1;
			row_cap     = '0;
			foreach (gen_parts[j]) gen_parts[j] = '0;
			gen_tail    = 1;
			gen_count   = 0;
			gen_rows    = 32'd1;
			gen_done    = 1'b0;
			gen_loading = 1'b0;
			due_parts.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_TOTAL_VALUE: n_total     = cfg_data[CFG_W-1:0];
					REG_MAX_PARTS:   k_row       = cfg_data[CFG_W-1:0];
					REG_MIN_FIRST:   first_floor = cfg_data[CFG_W-1:0];
					REG_ROW_LIMIT:   row_cap     = cfg_data;
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				result_no++;
				if (status_t'(status) == STAT_ROW && row_end) n_rows++;
				if (status_t'(status) == STAT_SKIPPED) n_skips++;
				if (status_t'(status) == STAT_FINISHED) n_finishes++;
				if (due_parts.size() == 0) begin
					report_mismatch("status of a result with nothing due", status, -1);
				end else begin
					want = due_parts.pop_front();
					if (part !== want.part) report_mismatch("part", part, want.part);
					if (row_end !== want.row_end)
						report_mismatch("row_end", row_end, want.row_end);
					if (status !== want.status) report_mismatch("status", status, want.status);
				end
			end

			if (in_valid && in_ready) begin
				if (command_t'(command) == CMD_LOAD) begin
					// The first load after a completed start partition opens a new one.
					if (!gen_loading) begin
						gen_count   = 0;
						gen_tail    = 1;
						gen_rows    = 32'd1;
						gen_done    = 1'b0;
						gen_loading = 1'b1;
					end
					// Parts beyond total_value are dropped, but the last flag still counts.
					if (gen_count < fit_range(n_total)) begin
						gen_count++;
						gen_parts[gen_count] = part_value;
						if (part_value > 1) gen_tail = gen_count;
					end
					if (load_last) begin
						for (int unsigned i = gen_count + 1; i <= MAX_TOTAL; i++)
							gen_parts[i] = 7'd1;
						gen_loading = 1'b0;
						push_row();
					end
				end else if (!gen_loading) begin
					// An advance in the middle of a load is ignored altogether.
					h = gen_tail;
					m = gen_count;
					if (gen_done) begin
						push_marker(STAT_FINISHED);
					end else if (gen_parts[1] < first_floor || gen_parts[1] <= 1 || h < 1 ||
							h > MAX_TOTAL || gen_parts[h] < 2) begin
						// First part too small, all ones reached, or a broken tail.
						gen_done = 1'b1;
						push_marker(STAT_FINISHED);
					end else begin
						if (gen_parts[h] == 2) begin
							// A trailing two splits into two ones.
							if (m < MAX_TOTAL) m++;
							gen_parts[h] = 7'd1;
							h--;
						end else begin
							// Lower the tail part and refill the remainder with copies of it.
							r = gen_parts[h] - 1;
							t = (m + 1 >= h) ? m + 1 - h : 0;
							gen_parts[h] = r[PART_W-1:0];
							while (t >= r && h < MAX_TOTAL) begin
								h++;
								gen_parts[h] = r[PART_W-1:0];
								t -= r;
							end
							if (t == 0) begin
								m = h;
							end else begin
								m = (h < MAX_TOTAL) ? h + 1 : MAX_TOTAL;
								if (t > 1 && h < MAX_TOTAL) begin
									h++;
									gen_parts[h] = t[PART_W-1:0];
								end
							end
						end
						gen_tail  = h;
						gen_count = m;
						if (m > fit_range(k_row)) begin
							push_marker(STAT_SKIPPED);
						end else begin
							push_row();
							gen_rows++;
							if (gen_rows == {1'b0, row_cap}) gen_done = 1'b1;
						end
					end
				end
			end
		end
		pending       <= due_parts.size();
		fail_count    <= mismatches;
		rows_seen     <= n_rows;
		skips_seen    <= n_skips;
		finishes_seen <= n_finishes;
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the integer partition generator
// Drives start partitions and advance commands under a range of register
// settings, with random gaps on both channels, while a separate checker
// predicts every row and marker and compares them as they leave the block.
// ----------------------------------------------------------------------------
module tb;
	import ipg_pkg::*;

	localparam int MAX_TOTAL = MAX_TOTAL_DEFAULT;

	// Number of counted input transactions in the random part.
	localparam int RANDOM_ITEMS = 220;

	// The slowest advance refills up to MAX_TOTAL parts and then streams a
	// full row, so twice that plus a margin covers any work still in flight.
	localparam int DRAIN_CYCLES = 2 * MAX_TOTAL + 16;

	// The longest correct quiet stretch is a drain followed by the longest
	// input gap, an advance and an output stall.
	localparam int IDLE_LIMIT = 2000;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	command_t             command    = CMD_LOAD;
	logic [PART_W-1:0]    part_value = '0;
	logic                 load_last  = 1'b0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [PART_W-1:0]    part;
	logic                 row_end;
	logic [STATUS_W-1:0]  status;
	logic                 cfg_we     = 1'b0;
	cfg_reg_t             cfg_index  = REG_TOTAL_VALUE;
	logic [LIMIT_W-1:0]   cfg_data   = '0;

	int fail_count;
	int pending;
	int rows_seen, skips_seen, finishes_seen;

	// Stimulus bookkeeping. An advance sent while a start partition is still
	// open does nothing, so it is not counted as a transaction of interest.
	int items_done     = 0;
	int settings_done  = 0;
	bit loading        = 1'b0;
	bit steady         = 1'b0;
	int ready_hold     = 0;
	int quiet_cycles   = 0;

	always #1 clk = ~clk;

	integer_partition_generator #(
		.MAX_TOTAL(MAX_TOTAL)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.part_value(part_value),
		.load_last (load_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.part      (part),
		.row_end   (row_end),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ipg_row_checker #(
		.MAX_TOTAL(MAX_TOTAL)
	) row_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.part_value   (part_value),
		.load_last    (load_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.part         (part),
		.row_end      (row_end),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.rows_seen    (rows_seen),
		.skips_seen   (skips_seen),
		.finishes_seen(finishes_seen)
	);

	// Wait drawn before each transaction on either channel. In a steady phase
	// both sides run flat out, which gives stretches without any idling.
	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 17);
	endfunction

	// Output side: after each accepted transaction, ready is dropped for a
	// freshly drawn number of cycles, then held high until the next one.
	always @(posedge clk or negedge arst_n) begin : sink
		int w;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			ready_hold <= 0;
		end else if (out_valid && out_ready) begin
			w = draw_wait();
			out_ready  <= (w == 0);
			ready_hold <= w - 1;
		end else if (!out_ready) begin
			if (ready_hold == 0) out_ready <= 1'b1;
			else ready_hold <= ready_hold - 1;
		end
	end

	// Watchdog: any accepted transaction or register write restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == IDLE_LIMIT - 1) begin
			$display("Timeout after %0d cycles without a transaction, %0d results still due",
				IDLE_LIMIT, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one input transaction after a random gap and returns at the edge
	// that accepts it. Valid is left high, so a back-to-back transaction only
	// changes the payload; the gap, when there is one, lowers it first.
	task automatic send(command_t cmd, int unsigned pv, bit last);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		part_value <= pv[PART_W-1:0];
		load_last  <= last;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_LOAD) begin
			items_done++;
			loading = !last;
		end else if (!loading) begin
			items_done++;
		end
	endtask

	// Brings the block to rest: every due result taken, then a pause long
	// enough for work that produces no result to have completed as well.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges, only while at rest.
	task automatic set_regs(int unsigned total, int unsigned k, int unsigned floor_v,
			int unsigned limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TOTAL_VALUE;
		cfg_data  <= LIMIT_W'(total);
		@(posedge clk);
		cfg_index <= REG_MAX_PARTS;
		cfg_data  <= LIMIT_W'(k);
		@(posedge clk);
		cfg_index <= REG_MIN_FIRST;
		cfg_data  <= LIMIT_W'(floor_v);
		@(posedge clk);
		cfg_index <= REG_ROW_LIMIT;
		cfg_data  <= LIMIT_W'(limit);
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_done++;
	endtask

	initial begin : stimulus
		int unsigned n, k, floor_v, limit, left, cap, p, top;
		int          directed_items;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings (one part of one): the start row, then the all-ones
		// stop, and the finished marker repeated by a further advance.
		send(CMD_LOAD, 1, 1'b1);
		send(CMD_ADVANCE, 0, 1'b0);
		send(CMD_ADVANCE, 0, 1'b0);

		// Start partition in three parts with an advance slipped in while it is
		// still open; later steps give rows and skipped partitions of four.
		settle();
		set_regs(6, 3, 1, 0);
		send(CMD_LOAD, 3, 1'b0);
		send(CMD_ADVANCE, 0, 1'b1);
		send(CMD_LOAD, 2, 1'b0);
		send(CMD_LOAD, 1, 1'b1);
		repeat (3) send(CMD_ADVANCE, 0, 1'b0);

		// More loaded parts than total_value allows, with the largest and the
		// zero part value, and a start row longer than the row itself.
		settle();
		set_regs(2, 1, 1, 0);
		send(CMD_LOAD, MAX_TOTAL, 1'b0);
		send(CMD_LOAD, 0, 1'b0);
		send(CMD_LOAD, 5, 1'b1);
		send(CMD_ADVANCE, MAX_TOTAL, 1'b1);

		// Full-width rows; the first part drops below min_first after one step.
		settle();
		set_regs(MAX_TOTAL, MAX_TOTAL, MAX_TOTAL, 31'h7FFF_FFFF);
		send(CMD_LOAD, MAX_TOTAL, 1'b1);
		repeat (2) send(CMD_ADVANCE, 0, 1'b0);

		// Row limit of two: the second row is emitted, the next advance finishes.
		settle();
		set_regs(MAX_TOTAL, 2, 1, 2);
		send(CMD_LOAD, MAX_TOTAL, 1'b1);
		repeat (2) send(CMD_ADVANCE, 0, 1'b0);

		// A start partition of all ones stops at once; a row limit of one never
		// matches.
		settle();
		set_regs(2, 2, 1, 1);
		send(CMD_LOAD, 1, 1'b0);
		send(CMD_LOAD, 1, 1'b1);
		send(CMD_ADVANCE, 0, 1'b0);

		// Random phases: mostly a well-formed start partition followed by a run
		// of advances, now and then a burst of arbitrary commands.
		directed_items = items_done;
		while (items_done - directed_items < RANDOM_ITEMS) begin
			settle();
			steady = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 7))
				0:       n = MAX_TOTAL;
				1:       n = $urandom_range(13, 40);
				default: n = $urandom_range(1, 12);
			endcase
			case ($urandom_range(0, 5))
				0:       k = MAX_TOTAL;
				1:       k = 1;
				default: k = $urandom_range(1, n);
			endcase
			case ($urandom_range(0, 5))
				0:       floor_v = $urandom_range(1, n);
				1:       floor_v = MAX_TOTAL;
				default: floor_v = 1;
			endcase
			case ($urandom_range(0, 7))
				0:       limit = $urandom_range(1, 12);
				1:       limit = 31'h7FFF_FFFF;
				default: limit = 0;
			endcase
			set_regs(n, k, floor_v, limit);

			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(2, 12))
					send(command_t'($urandom_range(0, 1)), $urandom_range(0, MAX_TOTAL),
						$urandom_range(0, 3) == 0);
			end else begin
				// Non-increasing parts summing to n, often the first partition [n].
				left = n;
				cap  = n;
				while (left > 0) begin
					top  = (left < cap) ? left : cap;
					p    = ($urandom_range(0, 2) == 0) ? top : $urandom_range(1, top);
					left = left - p;
					cap  = p;
					send(CMD_LOAD, p, left == 0);
				end
				repeat ($urandom_range(1, 25))
					send(CMD_ADVANCE, $urandom_range(0, MAX_TOTAL), $urandom_range(0, 1));
			end
		end
		settle();

		$display("Run covered %0d input transactions under %0d register settings.",
			items_done, settings_done);
		$display("Results seen: %0d rows, %0d skipped and %0d finished markers.",
			rows_seen, skips_seen, finishes_seen);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
